FILE: src/port_pair_pool_allocator_macros.svh
// Assertion macros for the port pair pool allocator checker.
// Expects clk and arst_n in the scope of each use.
`ifndef PORT_PAIR_POOL_ALLOCATOR_MACROS_SVH
`define PORT_PAIR_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PPA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("port pair pool allocator: check failed");

// next-cycle implication
`define PPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("port pair pool allocator: check failed");

`endif

FILE: src/ppa_pkg.sv
// Shared types and codes of the port pair pool allocator.
// No dependencies.
package ppa_pkg;

	localparam int unsigned PORT_W  = 16;
	localparam int unsigned ENTRY_W = 17;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned ST_W    = 2;
	localparam int unsigned CFG_ADDR_W = 2;

	// slots one release needs
	localparam int unsigned PAIR_SLOTS = 2;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_REFILL  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

	localparam logic [CFG_ADDR_W-1:0] REG_FIRST_PORT = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LAST_PORT  = 2'd1;

	localparam logic [PORT_W-1:0] PORT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [PORT_W-1:0] port;
	} req_t;

	typedef struct packed {
		logic [PORT_W-1:0] granted_port;
		logic [ST_W-1:0]   status;
	} rsp_t;

	typedef struct packed {
		logic [PORT_W-1:0] first_port;
		logic [PORT_W-1:0] last_port;
	} cfg_t;

endpackage

FILE: src/ppa_store.sv
// Free list storage: one write port, one read port, registered read data.
// Depends on ppa_pkg.
module ppa_store #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [ppa_pkg::ENTRY_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [ppa_pkg::ENTRY_W-1:0] rdata
);
	import ppa_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/ppa_ctrl.sv
// Sequencer of the port pair pool allocator: queue pointers, bounds,
// reads and writes of the free list and the result register.
// Depends on ppa_pkg; drives ppa_store.
module ppa_ctrl #(
	parameter int unsigned POOL_DEPTH = 4096,
	localparam int unsigned IW = $clog2(POOL_DEPTH),
	localparam int unsigned CW = $clog2(POOL_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ppa_pkg::cfg_t               cfg,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ppa_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output ppa_pkg::rsp_t               rsp,
	output logic                        mem_we,
	output logic [IW-1:0]               mem_waddr,
	output logic [ppa_pkg::ENTRY_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [IW-1:0]               mem_raddr,
	input  logic [ppa_pkg::ENTRY_W-1:0] mem_rdata
);
	import ppa_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_ALLOC1 = 6'b000010,
		S_ALLOC2 = 6'b000100,
		S_REL2   = 6'b001000,
		S_FILL   = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	localparam logic [IW-1:0] LAST_IDX = IW'(POOL_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(POOL_DEPTH);
	localparam logic [CW-1:0] PAIR_C   = CW'(PAIR_SLOTS);

	state_t state_q, state_d;
	logic [IW-1:0] head_q, head_d, tail_q, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic [PORT_W-1:0] low_q, low_d, high_q, high_d;
	logic [PORT_W-1:0] port_q, port_d, fill_q, fill_d, fill_hi_q, fill_hi_d;
	rsp_t res_q, res_d, rsp_q, rsp_d;
	logic rsp_valid_q, rsp_valid_d;

	logic slot_free;
	logic fin;
	rsp_t fin_rsp;
	logic [1:0] pops;
	logic [IW:0] head_sum;
	logic [IW-1:0] head_p1, tail_inc;
	logic [CW-1:0] free_cnt;
	logic [PORT_W-1:0] lo, hi;
	logic range_bad;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign head_p1   = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_inc  = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign free_cnt  = DEPTH_C - count_q;
	assign lo        = cfg.first_port + {{(PORT_W-1){1'b0}}, cfg.first_port[0]};
	assign hi        = cfg.last_port[0] ? cfg.last_port : cfg.last_port - 1'b1;
	assign range_bad = (req.port < low_q) || (req.port > high_q);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		low_d       = low_q;
		high_d      = high_q;
		port_d      = port_q;
		fill_d      = fill_q;
		fill_hi_d   = fill_hi_q;
		res_d       = res_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		mem_we      = 1'b0;
		mem_waddr   = tail_q;
		mem_wdata   = '0;
		mem_re      = 1'b0;
		mem_raddr   = head_q;
		fin         = 1'b0;
		fin_rsp     = '{granted_port: '0, status: ST_OK};
		pops        = 2'd0;
		head_sum    = '0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (req.operation)
						OP_ALLOC: begin
							if (count_q == '0) begin
								fin = 1'b1;
								fin_rsp.status = ST_EMPTY;
							end else begin
								mem_re  = 1'b1;
								state_d = S_ALLOC1;
							end
						end
						OP_RELEASE: begin
							if (range_bad) begin
								fin = 1'b1;
								fin_rsp.status = ST_RANGE;
							end else if (free_cnt < PAIR_C) begin
								fin = 1'b1;
								fin_rsp.status = ST_OVERFLOW;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = {1'b0, req.port};
								tail_d    = tail_inc;
								count_d   = count_q + 1'b1;
								port_d    = req.port;
								state_d   = S_REL2;
							end
						end
						OP_REFILL: begin
							if (cfg.first_port == PORT_MAX || cfg.last_port == '0) begin
								low_d  = PORT_W'(1);
								high_d = '0;
								fin    = 1'b1;
							end else begin
								low_d  = lo;
								high_d = hi;
								if (lo > hi) begin
									fin = 1'b1;
								end else begin
									fill_d    = lo;
									fill_hi_d = hi;
									state_d   = S_FILL;
								end
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC1: begin
				if (!mem_rdata[0]) begin
					pops = (count_q >= PAIR_C) ? 2'd2 : 2'd1;
					fin  = 1'b1;
					fin_rsp.granted_port = mem_rdata[PORT_W-1:0];
				end else if (count_q >= PAIR_C) begin
					mem_re    = 1'b1;
					mem_raddr = head_p1;
					state_d   = S_ALLOC2;
				end else begin
					pops = 2'd1;
					fin  = 1'b1;
					fin_rsp.status = ST_EMPTY;
				end
			end
			S_ALLOC2: begin
				pops = (count_q > PAIR_C) ? 2'd3 : 2'd2;
				fin  = 1'b1;
				fin_rsp.granted_port = mem_rdata[PORT_W-1:0];
			end
			S_REL2: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b0, port_q} + ENTRY_W'(1);
				tail_d    = tail_inc;
				count_d   = count_q + 1'b1;
				fin       = 1'b1;
			end
			S_FILL: begin
				if (count_q == DEPTH_C) begin
					fin = 1'b1;
					fin_rsp.status = ST_OVERFLOW;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = {1'b0, fill_q};
					tail_d    = tail_inc;
					count_d   = count_q + 1'b1;
					if (fill_q == fill_hi_q) begin
						fin = 1'b1;
					end else begin
						fill_d = fill_q + 1'b1;
					end
				end
			end
			S_FIN: begin
				if (slot_free) begin
					rsp_valid_d = 1'b1;
					rsp_d       = res_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (pops != 2'd0) begin
			head_sum = {1'b0, head_q} + (IW+1)'(pops);
			if (head_sum >= (IW+1)'(POOL_DEPTH)) begin
				head_sum = head_sum - (IW+1)'(POOL_DEPTH);
			end
			head_d  = head_sum[IW-1:0];
			count_d = count_q - CW'(pops);
		end

		if (fin) begin
			if (slot_free) begin
				rsp_valid_d = 1'b1;
				rsp_d       = fin_rsp;
				state_d     = S_IDLE;
			end else begin
				res_d   = fin_rsp;
				state_d = S_FIN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			low_q       <= '0;
			high_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			low_q       <= low_d;
			high_q      <= high_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		port_q    <= port_d;
		fill_q    <= fill_d;
		fill_hi_q <= fill_hi_d;
		res_q     <= res_d;
		rsp_q     <= rsp_d;
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: src/port_pair_pool_allocator.sv
// Port pair pool allocator: a FIFO free list of ports handed out in even/odd
// pairs, held in one synchronous memory of POOL_DEPTH 17-bit entries. Every
// request gives exactly one response. An allocate reads the front entry and
// also the entry after it when the front entry is odd and another entry
// follows it, one registered memory read per entry; an allocate from an
// empty list reads no entry. A release makes one memory write per port of
// the pair. A refill pushes its ports one write per cycle and stops with an
// overflow status when the store is full; a refill whose range is empty, a
// rejected release and the unused code make no memory access. A result
// waits in an output register while the next request is taken; a request
// that finishes while that register is still full holds until the register
// drains. The memory needs no clearing after reset: only entries already
// written are read.
// Depends on ppa_pkg, ppa_store and ppa_ctrl.
module port_pair_pool_allocator #(
	parameter int unsigned POOL_DEPTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ppa_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [ppa_pkg::PORT_W-1:0]     cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ppa_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output ppa_pkg::rsp_t                 rsp
);
	import ppa_pkg::*;

	localparam int unsigned IW = $clog2(POOL_DEPTH);

	cfg_t cfg_q;
	logic mem_we, mem_re;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_port <= PORT_W'(1);
			cfg_q.last_port  <= PORT_W'(1);
		end else if (cfg_valid) begin
			priority if (cfg_addr == REG_FIRST_PORT) begin
				cfg_q.first_port <= cfg_wdata;
			end else if (cfg_addr == REG_LAST_PORT) begin
				cfg_q.last_port <= cfg_wdata;
			end
		end
	end

	ppa_ctrl #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ppa_store #(
		.DEPTH(POOL_DEPTH),
		.AW   (IW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

FILE: src/ppa_checker.sv
// Port-level checks of the port pair pool allocator, bound to the top level.
// Depends on ppa_pkg and port_pair_pool_allocator_macros.svh.
`include "port_pair_pool_allocator_macros.svh"

module ppa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input ppa_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ppa_pkg::rsp_t rsp
);
	import ppa_pkg::*;

	// hold a stalled response
	`PPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// grant a port only with a good status
	`PPA_ASSERT_NOW(a_grant_ok, rsp_valid && (rsp.granted_port != '0), rsp.status == ST_OK)

	// never raise a response without a request taken or in work
	`PPA_ASSERT_NOW(a_rsp_cause, $rose(rsp_valid), $past(req_valid && req_ready) || $past(!req_ready))

	// keep release and refill responses free of a port
	`PPA_ASSERT_NOW(a_no_grant_on_fault, rsp_valid && (rsp.status == ST_RANGE || rsp.status == ST_OVERFLOW), rsp.granted_port == '0)

endmodule

bind port_pair_pool_allocator ppa_checker u_ppa_checker (.*);
